@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, character constants and glyph mapping for the integer-to-text block.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int unsigned HexBitsDefault = 64;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharMinus  = 8'h2d;

  // Reciprocal of ten: floor(x / 10) == (x * DivTenRecip) >> DivTenShift for 32-bit x.
  localparam logic [31:0] DivTenRecip = 32'hCCCC_CCCD;
  localparam int unsigned DivTenShift = 35;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } itoa_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } itoa_state_e;

  function automatic logic [7:0] itoa_glyph(logic [3:0] digit, logic upper);
    logic [7:0] base;
    logic [7:0] offs;
    if (digit < 4'd10) begin
      base = CharZero;
      offs = {4'b0000, digit};
    end else begin
      base = upper ? CharUpperA : CharLowerA;
      offs = {4'b0000, digit} - 8'd10;
    end
    return base + offs;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itoa_in_if.sv @@
// ----------------------------------------------------------------------------
// itoa_in_if
// Input stream: format selection and the integer to convert.
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/itoa_out_if.sv @@
// ----------------------------------------------------------------------------
// itoa_out_if
// Output stream: one ASCII character per beat, last flag on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/integer_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts one integer to ASCII text, most significant character first.
// ----------------------------------------------------------------------------
// Accepts one number, then extracts one digit per cycle with a shared unit
// (a divide by ten through a reciprocal multiply in decimal, a nibble shift
// in hex) into a small digit buffer, then plays the buffer back one
// character per beat through an output register, with an optional leading
// '-' for negative signed decimal. No new number is taken until the last
// character has gone into the output register, but the next number is
// accepted while that final character still waits there.
`default_nettype none

`include "assert_macros.svh"

module integer_to_ascii_digits #(
  parameter int unsigned HEX_BITS = itoa_pkg::HexBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itoa_in_if.sink   in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  localparam int unsigned HexDigits = (HEX_BITS + 3) / 4;
  localparam int unsigned Depth     = (HexDigits > 10) ? HexDigits : 10;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);

  itoa_state_e         st_q, st_d;
  itoa_op_e            op_q, op_d;
  logic                neg_q, neg_d;
  logic [HEX_BITS-1:0] work_q, work_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [3:0]          dig_q [Depth];

  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic                in_fire;
  logic                slot_free;
  logic                dig_we;
  logic [CntW-1:0]     cnt_m1;
  logic [IdxW-1:0]     rd_idx;
  logic [IdxW-1:0]     wr_idx;
  logic [31:0]         raw;
  logic [31:0]         mag;
  logic [3:0]          unit_digit;
  logic [HEX_BITS-1:0] unit_quot;
  logic                is_dec;

  assign in_i.ready      = (st_q == ST_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  assign slot_free = !out_valid_q || out_o.ready;
  assign cnt_m1    = cnt_q - CntW'(1);
  assign rd_idx    = cnt_m1[IdxW-1:0];
  assign wr_idx    = cnt_q[IdxW-1:0];
  assign raw       = in_i.value[31:0];
  assign mag       = raw[31] ? (32'd0 - raw) : raw;
  assign is_dec    = (op_q == OP_SDEC) || (op_q == OP_UDEC);

  itoa_digit_unit #(
    .HEX_BITS (HEX_BITS)
  ) u_digit (
    .is_dec_i (is_dec),
    .work_i   (work_q),
    .digit_o  (unit_digit),
    .quot_o   (unit_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    neg_q      <= neg_d;
    work_q     <= work_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (dig_we) begin
      dig_q[wr_idx] <= unit_digit;
    end
  end

  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    neg_d       = neg_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    dig_we      = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = itoa_op_e'(in_i.operation);
          cnt_d = '0;
          case (itoa_op_e'(in_i.operation))
            OP_SDEC: begin
              neg_d  = raw[31];
              work_d = HEX_BITS'(mag);
            end
            OP_UDEC: begin
              neg_d  = 1'b0;
              work_d = HEX_BITS'(raw);
            end
            default: begin
              neg_d  = 1'b0;
              work_d = in_i.value[HEX_BITS-1:0];
            end
          endcase
          st_d = ST_CONV;
        end
      end
      ST_CONV: begin
        // Store the lowest digit; divide (shift in hex) until nothing is left.
        dig_we = 1'b1;
        work_d = unit_quot;
        cnt_d  = cnt_q + CntW'(1);
        if (unit_quot == '0 || cnt_q == CntW'(Depth - 1)) begin
          st_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
          out_last_d  = 1'b0;
          st_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Play the buffer back from the top.
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_glyph(dig_q[rd_idx], op_q == OP_HEXU);
          out_last_d  = (cnt_q == CntW'(1));
          cnt_d       = cnt_m1;
          if (cnt_q == CntW'(1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_emit_has_digit, clk_i, rst_ni, st_q == ST_EMIT, cnt_q != '0)
  `ASSERT_NEXT(a_accept_starts_conv, clk_i, rst_ni, in_fire, st_q == ST_CONV && cnt_q == '0)
  `ASSERT_IMPL(a_load_only_when_emitting, clk_i, rst_ni, $rose(out_valid_q),
               $past(st_q) == ST_SIGN || $past(st_q) == ST_EMIT)
  `ASSERT_IMPL(a_minus_only_negative, clk_i, rst_ni, st_q == ST_SIGN,
               neg_q && op_q == OP_SDEC)

endmodule

`default_nettype wire

@@ hw/rtl/itoa_digit_unit.sv @@
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Shared digit extractor: divide by ten (decimal) or shift by a nibble (hex).
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_digit_unit #(
  parameter int unsigned HEX_BITS = itoa_pkg::HexBitsDefault
) (
  input  wire logic                is_dec_i,
  input  wire logic [HEX_BITS-1:0] work_i,
  output logic      [3:0]          digit_o,
  output logic      [HEX_BITS-1:0] quot_o
);
  import itoa_pkg::*;

  logic [31:0] x;
  logic [63:0] prod;
  logic [28:0] q10;
  logic [31:0] q10_x10;
  logic [31:0] rem;

  assign x       = work_i[31:0];
  assign prod    = {32'd0, x} * {32'd0, DivTenRecip};
  assign q10     = prod[63:DivTenShift];
  assign q10_x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign rem     = x - q10_x10;

  always_comb begin
    if (is_dec_i) begin
      digit_o = rem[3:0];
      quot_o  = HEX_BITS'(q10);
    end else begin
      digit_o = work_i[3:0];
      quot_o  = work_i >> 4;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_integer_to_ascii_digits.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking bench for the integer-to-text converter.
// ----------------------------------------------------------------------------
// Sends numbers in all four formats and predicts the character stream of
// each one. The directed numbers cover zero, the signed extremes, ignored
// upper bits in decimal and full-width hex. Random numbers follow. The
// scoreboard checks every output beat against the oldest predicted
// character. Both sides idle at random, and the receiver holds off once for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_digits;
  import itoa_pkg::*;

  localparam int unsigned HexBits     = itoa_pkg::HexBitsDefault;
  localparam int unsigned RandomCount = 480;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 2_000_000;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  class digit_scoreboard;
    text_beat_t  pending_text[$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned numbers_by_op[4];

    // Predict the text of one accepted number, most significant first.
    function void note_number(itoa_op_e op, logic [63:0] value);
      logic [7:0]  digits[16];
      int          count;
      int          idx;
      logic [31:0] mag;
      logic [63:0] bits;
      logic [3:0]  nib;
      text_beat_t  beat;
      count = 0;
      numbers_by_op[op]++;
      if (op == OP_SDEC || op == OP_UDEC) begin
        mag = value[31:0];
        if (op == OP_SDEC && mag[31]) begin
          // Two's complement negate; the most negative value maps to 2^31.
          mag = -mag;
          beat.character = CharMinus;
          beat.last = 1'b0;
          pending_text.push_back(beat);
        end
        do begin
          digits[count] = CharZero + 8'(mag % 32'd10);
          mag = mag / 32'd10;
          count++;
        end while (mag != 32'd0);
      end else begin
        bits = value;
        if (HexBits < 64) begin
          bits &= (64'd1 << HexBits) - 64'd1;
        end
        do begin
          nib = bits[3:0];
          if (nib < 4'd10) begin
            digits[count] = CharZero + {4'b0000, nib};
          end else begin
            digits[count] = ((op == OP_HEXU) ? CharUpperA : CharLowerA)
                            + {4'b0000, nib} - 8'd10;
          end
          bits = bits >> 4;
          count++;
        end while (bits != 64'd0);
      end
      for (idx = count - 1; idx >= 0; idx--) begin
        beat.character = digits[idx];
        beat.last = (idx == 0);
        pending_text.push_back(beat);
      end
    endfunction

    function void check_char(logic [7:0] character, logic last);
      text_beat_t want;
      chars_checked++;
      if (pending_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] character %02h last=%0b arrived with nothing pending",
                   $realtime, character, last);
        end
        return;
      end
      want = pending_text.pop_front();
      if (character !== want.character || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] character beat: expected %02h last=%0b, got %02h last=%0b",
                   $realtime, want.character, want.last, character, last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cycle_count = 0;
  bit          pressure_done = 1'b0;

  digit_scoreboard board = new();

  itoa_in_if  in_bus();
  itoa_out_if out_bus();

  integer_to_ascii_digits #(
    .HEX_BITS(HexBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d characters still pending",
               board.pending_text.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Watch both channels; a beat counts at an edge with valid and ready high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        board.note_number(itoa_op_e'(in_bus.operation), in_bus.value);
      end
      if (out_bus.valid && out_bus.ready) begin
        board.check_char(out_bus.character, out_bus.last);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [63:0] draw_number_value();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 20));
      2:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      3:       return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 15))};
      4:       return {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 15))};
      default: return {$urandom, $urandom >> $urandom_range(0, 31)};
    endcase
  endfunction

  task automatic send_number(input itoa_op_e op, input logic [63:0] value);
    int unsigned gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.value     <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Receiver: random stalls, stall-free stretches, and one long hold-off.
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && cycle_count > 3000) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        pressure_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(30, 90)) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  initial begin
    itoa_op_e    op;
    logic [63:0] value;
    rst_ni           <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_SDEC;
    in_bus.value     <= 64'd0;
    out_bus.ready    <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Signed decimal: zero, small, minus one, both extremes, ignored upper bits.
    send_number(OP_SDEC, 64'd0);
    send_number(OP_SDEC, 64'd1);
    send_number(OP_SDEC, 64'hFFFF_FFFF);
    send_number(OP_SDEC, 64'h8000_0000);
    send_number(OP_SDEC, 64'h7FFF_FFFF);
    send_number(OP_SDEC, 64'hDEAD_BEEF_0000_007B);
    send_number(OP_SDEC, 64'h0000_0001_FFFF_FFF6);
    // Unsigned decimal.
    send_number(OP_UDEC, 64'd0);
    send_number(OP_UDEC, 64'hFFFF_FFFF);
    send_number(OP_UDEC, 64'hFFFF_FFFF_0000_0000);
    send_number(OP_UDEC, 64'd1_000_000_000);
    send_number(OP_UDEC, 64'd9);
    // Hex, both cases, full width.
    send_number(OP_HEXL, 64'd0);
    send_number(OP_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(OP_HEXL, 64'h0123_4567_89AB_CDEF);
    send_number(OP_HEXL, 64'h8000_0000_0000_0000);
    send_number(OP_HEXL, 64'hA);
    send_number(OP_HEXU, 64'd0);
    send_number(OP_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(OP_HEXU, 64'hFEDC_BA98_7654_3210);
    send_number(OP_HEXU, 64'd1);
    send_number(OP_HEXU, 64'h0000_0000_F000_0000);

    repeat (RandomCount) begin
      op    = itoa_op_e'($urandom_range(0, 3));
      value = draw_number_value();
      send_number(op, value);
    end
    in_bus.valid <= 1'b0;

    // Let the last number land in the scoreboard, then drain.
    @(posedge clk_i);
    while (board.pending_text.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d numbers: signed %0d, unsigned %0d, hex lower %0d, hex upper %0d",
             board.numbers_by_op[0] + board.numbers_by_op[1] + board.numbers_by_op[2]
             + board.numbers_by_op[3], board.numbers_by_op[0], board.numbers_by_op[1],
             board.numbers_by_op[2], board.numbers_by_op[3]);
    $display("Checked %0d characters, %0d bad, with one %0d-cycle receiver hold-off",
             board.chars_checked, board.mismatches, HoldCycles);
    if (board.mismatches == 0 && board.pending_text.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
